/* src/lur_pkg.sv */
package lur_pkg;

  localparam int IMAGE_WIDTH  = 1024;
  localparam int IMAGE_HEIGHT = 512;
  localparam int COL_W        = 10;
  localparam int LINE_W       = 9;
  localparam int PIX_W        = 8;
  localparam int ADDR_W       = COL_W + LINE_W;
  localparam int FOCAL_W      = 20;
  localparam int COEF_W       = 32;
  localparam int QUO_W        = 31;
  localparam int FRAC_PIX     = 8;

  localparam logic [2:0] REG_FOCAL_X  = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] REG_CENTRE_X = 3'd2;
  localparam logic [2:0] REG_CENTRE_Y = 3'd3;
  localparam logic [2:0] REG_K1       = 3'd4;
  localparam logic [2:0] REG_K2       = 3'd5;
  localparam logic [2:0] REG_P1       = 3'd6;
  localparam logic [2:0] REG_P2       = 3'd7;

  localparam logic signed [COEF_W-1:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [COEF_W-1:0] Q_MIN = 32'sh80000000;
  localparam logic signed [39:0]       ONE_Q24 = 40'sd16777216;

  typedef struct packed {
    logic               valid;
    logic               query;
    logic [COL_W-1:0]   column;
    logic [LINE_W-1:0]  line;
    logic [PIX_W-1:0]   pixel;
  } tag_t;

  typedef struct packed {
    logic [FOCAL_W-1:0]        focal_x;
    logic [FOCAL_W-1:0]        focal_y;
    logic [FOCAL_W-1:0]        centre_x;
    logic [FOCAL_W-1:0]        centre_y;
    logic signed [COEF_W-1:0]  k1;
    logic signed [COEF_W-1:0]  k2;
    logic signed [COEF_W-1:0]  p1;
    logic signed [COEF_W-1:0]  p2;
  } cfg_t;

  typedef struct packed {
    tag_t              tag;
    logic              in_frame;
    logic [ADDR_W-1:0] addr;
  } req_t;

  function automatic logic signed [COEF_W-1:0] sat32(input logic signed [39:0] v);
    if (v > 40'sh007fffffff) return Q_MAX;
    if (v < -40'sh0080000000) return Q_MIN;
    return v[COEF_W-1:0];
  endfunction

  // Q.24 product back to Q.24, floor then clamp
  function automatic logic signed [COEF_W-1:0] qsat(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 24;
    return sat32(s[39:0]);
  endfunction

endpackage

/* src/lur_norm.sv */
module lur_norm
  import lur_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  tag_t                      tag_in,
  input  cfg_t                      cfg,
  output tag_t                      tag_out,
  output logic signed [COEF_W-1:0]  x_out,
  output logic signed [COEF_W-1:0]  y_out
);

  localparam int NSTG = QUO_W;

  tag_t tag_pipe [0:NSTG+1];
  logic signed [COEF_W-1:0] res [0:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= NSTG + 1; s++) tag_pipe[s] <= '0;
    end else if (adv) begin
      tag_pipe[0] <= tag_in;
      for (int s = 1; s <= NSTG + 1; s++) tag_pipe[s] <= tag_pipe[s-1];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [COL_W-1:0]   pos;
    logic [FOCAL_W-1:0] centre;
    logic [FOCAL_W-1:0] focal;
    logic [FOCAL_W-1:0] fe;
    logic signed [21:0] diff;
    logic [20:0]        mag;
    logic [FOCAL_W-1:0] rem [0:NSTG];
    logic [QUO_W-1:0]   quo [0:NSTG];
    logic [6:0]         low [0:NSTG];
    logic               neg [0:NSTG];
    logic               sat [0:NSTG];
    logic [COEF_W-1:0]  qv;
    logic signed [COEF_W-1:0] outv;

    assign pos    = (l == 0) ? tag_in.column : COL_W'(tag_in.line);
    assign centre = (l == 0) ? cfg.centre_x : cfg.centre_y;
    assign focal  = (l == 0) ? cfg.focal_x : cfg.focal_y;
    assign fe     = (focal == '0) ? FOCAL_W'(1) : focal;
    assign diff   = $signed({4'b0, pos, 8'b0}) - $signed({2'b0, centre});
    assign mag    = diff[21] ? 21'(-diff) : diff[20:0];

    // quotient fits 31 bits unless |diff| >= focal*128
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[0] <= FOCAL_W'(mag[20:7]);
        quo[0] <= '0;
        low[0] <= mag[6:0];
        neg[0] <= diff[21];
        sat[0] <= {6'b0, mag} >= {fe, 7'b0};
      end
    end

    for (genvar s = 1; s <= NSTG; s++) begin : g_stg
      localparam int BIT = NSTG - s;
      logic        nbit;
      logic [20:0] rn;
      logic        ge;
      if (BIT >= 24) begin : g_num
        assign nbit = low[s-1][BIT-24];
      end else begin : g_zero
        assign nbit = 1'b0;
      end
      assign rn = {rem[s-1], nbit};
      assign ge = rn >= {1'b0, fe};
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[s] <= ge ? FOCAL_W'(rn - {1'b0, fe}) : rn[FOCAL_W-1:0];
          quo[s] <= {quo[s-1][QUO_W-2:0], ge};
          low[s] <= low[s-1];
          neg[s] <= neg[s-1];
          sat[s] <= sat[s-1];
        end
      end
    end

    assign qv   = {1'b0, quo[NSTG]};
    assign outv = sat[NSTG] ? (neg[NSTG] ? Q_MIN : Q_MAX)
                            : (neg[NSTG] ? $signed(-qv) : $signed(qv));

    always_ff @(posedge clk) begin
      if (adv) res[l] <= outv;
    end
  end

  assign tag_out = tag_pipe[NSTG+1];
  assign x_out   = res[0];
  assign y_out   = res[1];

endmodule

/* src/lur_distort.sv */
module lur_distort
  import lur_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  tag_t                      tag_in,
  input  logic signed [COEF_W-1:0]  x_in,
  input  logic signed [COEF_W-1:0]  y_in,
  input  cfg_t                      cfg,
  output req_t                      req
);

  localparam int NST = 9;

  tag_t tag_pipe [0:NST-1];

  logic signed [63:0] px2, py2, pxy;
  logic signed [COEF_W-1:0] x1, y1;
  logic signed [COEF_W-1:0] x2, y2, xy, r2a, x2s, y2s;
  logic signed [63:0] pr4;
  logic signed [COEF_W-1:0] tx, ty, r2b, xyb, x3, y3;
  logic signed [COEF_W-1:0] r4, txc, tyc, r2c, xyc, x4, y4;
  logic signed [63:0] mk1, mk2, mp1xy, mp2xy, mp2tx, mp1ty;
  logic signed [COEF_W-1:0] x5, y5;
  logic signed [COEF_W-1:0] rad, x6, y6;
  logic signed [39:0] ax, ay, ax7, ay7;
  logic signed [63:0] pxr, pyr;
  logic signed [COEF_W-1:0] xd, yd;
  logic signed [63:0] pu, pv;
  logic signed [63:0] ud, vd;
  logic signed [COEF_W-1:0] x2c, y2c, xyq, r2q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NST; s++) tag_pipe[s] <= '0;
    end else if (adv) begin
      tag_pipe[0] <= tag_in;
      for (int s = 1; s < NST; s++) tag_pipe[s] <= tag_pipe[s-1];
    end
  end

  assign x2c = qsat(px2);
  assign y2c = qsat(py2);
  assign xyq = qsat(pxy);
  assign r2q = sat32(40'(x2c) + 40'(y2c));

  always_ff @(posedge clk) begin
    if (adv) begin
      px2 <= 64'(x_in) * 64'(x_in);
      py2 <= 64'(y_in) * 64'(y_in);
      pxy <= 64'(x_in) * 64'(y_in);
      x1 <= x_in;
      y1 <= y_in;

      x2s <= x2c;
      y2s <= y2c;
      xy  <= xyq;
      r2a <= r2q;
      x2  <= x1;
      y2  <= y1;

      pr4 <= 64'(r2a) * 64'(r2a);
      tx  <= sat32(40'(r2a) + 40'(x2s) + 40'(x2s));
      ty  <= sat32(40'(r2a) + 40'(y2s) + 40'(y2s));
      r2b <= r2a;
      xyb <= xy;
      x3  <= x2;
      y3  <= y2;

      r4  <= qsat(pr4);
      txc <= tx;
      tyc <= ty;
      r2c <= r2b;
      xyc <= xyb;
      x4  <= x3;
      y4  <= y3;

      mk1   <= 64'(cfg.k1) * 64'(r2c);
      mk2   <= 64'(cfg.k2) * 64'(r4);
      mp1xy <= 64'(cfg.p1) * 64'(xyc);
      mp2xy <= 64'(cfg.p2) * 64'(xyc);
      mp2tx <= 64'(cfg.p2) * 64'(txc);
      mp1ty <= 64'(cfg.p1) * 64'(tyc);
      x5 <= x4;
      y5 <= y4;

      rad <= sat32(ONE_Q24 + 40'(qsat(mk1)) + 40'(qsat(mk2)));
      ax  <= 40'(qsat(mp1xy)) + 40'(qsat(mp1xy)) + 40'(qsat(mp2tx));
      ay  <= 40'(qsat(mp1ty)) + 40'(qsat(mp2xy)) + 40'(qsat(mp2xy));
      x6  <= x5;
      y6  <= y5;

      pxr <= 64'(x6) * 64'(rad);
      pyr <= 64'(y6) * 64'(rad);
      ax7 <= ax;
      ay7 <= ay;

      xd <= sat32(40'(qsat(pxr)) + ax7);
      yd <= sat32(40'(qsat(pyr)) + ay7);

      pu <= $signed({44'b0, cfg.focal_x}) * 64'(xd);
      pv <= $signed({44'b0, cfg.focal_y}) * 64'(yd);
    end
  end

  assign ud = (pu >>> 24) + $signed({44'b0, cfg.centre_x});
  assign vd = (pv >>> 24) + $signed({44'b0, cfg.centre_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      req.tag <= '0;
    end else if (adv) begin
      req.tag      <= tag_pipe[NST-1];
      req.in_frame <= (ud >= 0) && (vd >= 0) &&
                      (ud < 64'(IMAGE_WIDTH) * 256) && (vd < 64'(IMAGE_HEIGHT) * 256);
      req.addr     <= {vd[FRAC_PIX +: LINE_W], ud[FRAC_PIX +: COL_W]};
    end
  end

endmodule

/* src/lur_store.sv */
module lur_store
  import lur_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  req_t              req,
  output logic              res_valid,
  output logic [PIX_W-1:0]  res_pixel,
  output logic              res_inside
);

  localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;

  logic [PIX_W-1:0]  mem [0:DEPTH-1];
  logic [PIX_W-1:0]  rdata;
  logic [ADDR_W-1:0] waddr;
  logic              load_ok;
  logic              in_frame;

  assign waddr   = {req.tag.line, req.tag.column};
  assign load_ok = (32'(req.tag.column) < IMAGE_WIDTH) && (32'(req.tag.line) < IMAGE_HEIGHT);

  // loads and queries reach this port in request order, one per cycle while adv is high
  always_ff @(posedge clk) begin
    if (adv && req.tag.valid && !req.tag.query && load_ok) mem[waddr] <= req.tag.pixel;
    if (adv) rdata <= mem[req.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= req.tag.valid && req.tag.query;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) in_frame <= req.in_frame;
  end

  assign res_pixel  = in_frame ? rdata : '0;
  assign res_inside = in_frame;

endmodule

/* src/lens_undistort_remap.sv */
// Grayscale lens undistortion remapper, radial k1/k2 and tangential p1/p2,
// nearest-pixel sampling from an internal 1024x512 frame store.
// Input stream (s_*): s_tuser is the action, 0 loads a pixel, 1 queries.
//   A load writes pixel_in at (column, line). A query maps output pixel
//   (column, line) into the distorted image and returns one result.
// Output stream (m_*): one request per query, none per load, in order.
// Config port: cfg_we with cfg_index and cfg_data writes one register;
//   write only while no request is in flight.
// Throughput: one request per cycle while the pipeline advances. From acceptance
//   to m_tvalid a request passes the two bit-serial pipelined dividers that
//   normalize the coordinates, the multiplier pipeline and the frame store read.
// The whole pipeline advances together; while m_tvalid is high and m_tready
//   is low it holds and s_tready drops, so nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and restores the default
//   camera model; the frame store is not cleared, so load pixels before
//   querying them.
module lens_undistort_remap
  import lur_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [9:0] column, [18:10] line, [26:19] pixel_in
  input  logic         s_tuser,   // [0] action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,   // [7:0] pixel_out
  output logic         m_tuser,   // [0] inside_res
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  cfg_t  cfg;
  tag_t  tag_in, tag_norm;
  req_t  req;
  logic  adv;
  logic signed [COEF_W-1:0] xn, yn;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x  <= 20'd117415;
      cfg.focal_y  <= 20'd117068;
      cfg.centre_x <= 20'd94007;
      cfg.centre_y <= 20'd63584;
      cfg.k1       <= -32'sd4736344;
      cfg.k2       <= 32'sd1240827;
      cfg.p1       <= 32'sd3248;
      cfg.p2       <= 32'sd296;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOCAL_X:  cfg.focal_x  <= cfg_data[FOCAL_W-1:0];
        REG_FOCAL_Y:  cfg.focal_y  <= cfg_data[FOCAL_W-1:0];
        REG_CENTRE_X: cfg.centre_x <= cfg_data[FOCAL_W-1:0];
        REG_CENTRE_Y: cfg.centre_y <= cfg_data[FOCAL_W-1:0];
        REG_K1:       cfg.k1       <= $signed(cfg_data);
        REG_K2:       cfg.k2       <= $signed(cfg_data);
        REG_P1:       cfg.p1       <= $signed(cfg_data);
        REG_P2:       cfg.p2       <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  assign tag_in.valid  = s_tvalid;
  assign tag_in.query  = s_tuser;
  assign tag_in.column = s_tdata[9:0];
  assign tag_in.line   = s_tdata[18:10];
  assign tag_in.pixel  = s_tdata[26:19];

  lur_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .tag_in  (tag_in),
    .cfg     (cfg),
    .tag_out (tag_norm),
    .x_out   (xn),
    .y_out   (yn)
  );

  lur_distort u_distort (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .tag_in (tag_norm),
    .x_in   (xn),
    .y_in   (yn),
    .cfg    (cfg),
    .req    (req)
  );

  lur_store u_store (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .req        (req),
    .res_valid  (m_tvalid),
    .res_pixel  (m_tdata),
    .res_inside (m_tuser)
  );

endmodule
